### src/sync_tag_hunt_header_capture_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sync tag hunter
// Shorthand for clocked assertions that are disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef SYNC_TAG_HUNT_HEADER_CAPTURE_ASSERT_SVH
`define SYNC_TAG_HUNT_HEADER_CAPTURE_ASSERT_SVH

// Same-cycle implication.
`define STH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define STH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/sthhc_pkg.sv
// ----------------------------------------------------------------------------
// Sync tag hunter package
// Tag bytes, header length, counter and data widths, result kind and byte order codes.
// ----------------------------------------------------------------------------
`default_nettype none

package sthhc_pkg;

  localparam int unsigned HdrLen   = 12;
  localparam int unsigned HdrLenW  = $clog2(HdrLen + 1);
  localparam int unsigned SkipCntW = 32;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 48;

  localparam logic [3:0][7:0] TagBytes = {8'h37, 8'h8A, 8'h1F, 8'hD4};

  typedef enum logic [1:0] {
    KindSync    = 2'd0,
    KindHeader  = 2'd1,
    KindEndHunt = 2'd2,
    KindShort   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    OrderNone = 2'd0,
    OrderFwd  = 2'd1,
    OrderRev  = 2'd2
  } order_e;

endpackage

`default_nettype wire

### src/sync_tag_hunt_header_capture.sv
// ----------------------------------------------------------------------------
// Sync tag hunter with header capture
// Scans a byte stream for the tag D4 1F 8A 37 in either byte order, then
// passes the following header bytes through.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one request per stream byte in s_axis_tdata;
//   s_axis_tlast marks an end-of-stream request that carries no byte.
//   The master channel delivers results: m_axis_tuser holds the kind (sync
//   found, header byte, end while hunting, short header), m_axis_tdata the
//   header byte, the order flag and the skip count, and m_axis_tlast marks
//   the last byte of the header.
//   Bytes that do not complete a tag produce no result.
//   A result appears on the master side in the cycle after its request is
//   accepted. One request is taken every cycle unless the receiver stalls;
//   the scan state and the output register are updated together from the
//   incoming byte. When the receiver stalls, the result waits in the output
//   register and s_axis_tready drops until it is taken; a new request is
//   accepted in the same cycle as the waiting result leaves.
//   Reset clears the hunt state and the skip count and empties the output
//   register. An end-of-stream request also restarts the hunt.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sync_tag_hunt_header_capture_assert.svh"

module sync_tag_hunt_header_capture (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  // [7:0] data_byte
  input  wire logic [sthhc_pkg::InDataW-1:0] s_axis_tdata,
  input  wire logic                          s_axis_tlast,
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  // [7:0] header_byte, [8] reversed_order, [40:9] skipped_bytes, [47:41] zero
  output      logic [sthhc_pkg::OutDataW-1:0] m_axis_tdata,
  // [1:0] result_kind
  output      logic [1:0]                    m_axis_tuser,
  output      logic                          m_axis_tlast
);

  import sthhc_pkg::*;

  // Scan state
  logic                in_hdr_q,   in_hdr_d;
  order_e              order_q,    order_d;
  logic [1:0]          tag_cnt_q,  tag_cnt_d;
  logic [HdrLenW-1:0]  hdr_left_q, hdr_left_d;
  logic [SkipCntW-1:0] skip_q,     skip_d;

  // Output register
  logic                out_vld_q,  out_vld_d;
  kind_e               kind_q,     kind_d;
  logic [7:0]          hbyte_q,    hbyte_d;
  logic                rev_q,      rev_d;
  logic [SkipCntW-1:0] oskip_q,    oskip_d;
  logic                olast_q,    olast_d;

  logic                s_acc;
  logic                emit;
  logic                rev_now;
  logic [1:0]          want_idx;
  logic [7:0]          want_byte;
  logic [2:0]          skip_inc;
  logic [SkipCntW:0]   skip_sum;

  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign rev_now       = (order_q == OrderRev);

  // Next expected tag byte; reversed order walks the tag from the end.
  assign want_idx  = (order_q == OrderFwd) ? tag_cnt_q : ~tag_cnt_q;
  assign want_byte = TagBytes[want_idx];

  always_comb begin
    in_hdr_d   = in_hdr_q;
    order_d    = order_q;
    tag_cnt_d  = tag_cnt_q;
    hdr_left_d = hdr_left_q;
    skip_d     = skip_q;
    skip_inc   = 3'd0;
    emit       = 1'b0;
    kind_d     = kind_q;
    hbyte_d    = 8'd0;
    rev_d      = 1'b0;
    oskip_d    = '0;
    olast_d    = 1'b0;

    if (s_axis_tlast) begin
      emit       = 1'b1;
      kind_d     = in_hdr_q ? KindShort : KindEndHunt;
      rev_d      = in_hdr_q && rev_now;
      in_hdr_d   = 1'b0;
      order_d    = OrderNone;
      tag_cnt_d  = 2'd0;
      hdr_left_d = '0;
      skip_d     = '0;
    end else if (in_hdr_q) begin
      emit    = 1'b1;
      kind_d  = KindHeader;
      hbyte_d = s_axis_tdata;
      rev_d   = rev_now;
      if (hdr_left_q <= HdrLenW'(1)) begin
        olast_d    = 1'b1;
        in_hdr_d   = 1'b0;
        order_d    = OrderNone;
        tag_cnt_d  = 2'd0;
        hdr_left_d = '0;
        skip_d     = '0;
      end else begin
        hdr_left_d = hdr_left_q - HdrLenW'(1);
      end
    end else if (order_q == OrderNone || tag_cnt_q == 2'd0) begin
      // Looking for the first tag byte.
      if (s_axis_tdata == TagBytes[0]) begin
        order_d   = OrderFwd;
        tag_cnt_d = 2'd1;
      end else if (s_axis_tdata == TagBytes[3]) begin
        order_d   = OrderRev;
        tag_cnt_d = 2'd1;
      end else begin
        order_d   = OrderNone;
        tag_cnt_d = 2'd0;
        skip_inc  = 3'd1;
      end
    end else if (s_axis_tdata != want_byte) begin
      // The partial tag and the mismatching byte all count as skipped.
      skip_inc  = {1'b0, tag_cnt_q} + 3'd1;
      order_d   = OrderNone;
      tag_cnt_d = 2'd0;
    end else if (tag_cnt_q == 2'd3) begin
      emit       = 1'b1;
      kind_d     = KindSync;
      rev_d      = rev_now;
      oskip_d    = skip_q;
      in_hdr_d   = 1'b1;
      tag_cnt_d  = 2'd0;
      hdr_left_d = HdrLenW'(HdrLen);
      skip_d     = '0;
    end else begin
      tag_cnt_d = tag_cnt_q + 2'd1;
    end

    // The skip count saturates at its maximum.
    skip_sum = {1'b0, skip_q} + {{(SkipCntW - 2){1'b0}}, skip_inc};
    if (skip_inc != 3'd0) begin
      skip_d = skip_sum[SkipCntW] ? {SkipCntW{1'b1}} : skip_sum[SkipCntW-1:0];
    end

    out_vld_d = out_vld_q && !m_axis_tready;
    if (s_acc && emit) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_hdr_q   <= 1'b0;
      order_q    <= OrderNone;
      tag_cnt_q  <= 2'd0;
      hdr_left_q <= '0;
      skip_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (s_acc) begin
        in_hdr_q   <= in_hdr_d;
        order_q    <= order_d;
        tag_cnt_q  <= tag_cnt_d;
        hdr_left_q <= hdr_left_d;
        skip_q     <= skip_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc && emit) begin
      kind_q  <= kind_d;
      hbyte_q <= hbyte_d;
      rev_q   <= rev_d;
      oskip_q <= oskip_d;
      olast_q <= olast_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {(OutDataW - SkipCntW - 9)'(0), oskip_q, rev_q, hbyte_q};

  `STH_ASSERT_NOW(a_hdr_count_range, in_hdr_q,
    (hdr_left_q != '0) && (hdr_left_q <= HdrLenW'(HdrLen)),
    "Header phase with an out-of-range byte count")

  `STH_ASSERT_NEXT(a_end_restarts, s_acc && s_axis_tlast,
    !in_hdr_q && (skip_q == '0) && (order_q == OrderNone),
    "End of stream did not restart the hunt")

  `STH_ASSERT_NOW(a_last_hdr_leaves, out_vld_q && (kind_q == KindHeader) && olast_q,
    !in_hdr_q,
    "Still in the header phase after its last byte")

  `STH_ASSERT_NOW(a_sync_enters_hdr, out_vld_q && (kind_q == KindSync),
    in_hdr_q || !s_axis_tready || (skip_q == '0),
    "Sync result without a fresh hunt or header phase")

endmodule

`default_nettype wire

### bench/tb_sync_tag_hunt_header_capture.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the sync tag hunter with header capture
// Sends byte streams with the tag in both byte orders, broken tags, short
// headers and ends of stream. Every result is compared with a behavioral
// model of the hunt that runs alongside, with random stalls on both sides outside a calm phase.
// ----------------------------------------------------------------------------

module tb_sync_tag_hunt_header_capture;
  import sthhc_pkg::*;

  localparam int unsigned StallLimit = 2000;

  typedef struct packed {
    logic [6:0]  pad;
    kind_e       kind;
    logic [7:0]  hdr;
    logic        rev;
    logic [31:0] skip;
    logic        last;
  } hunt_result_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;
  logic                m_axis_tlast;

  // Model state of the hunt.
  logic                hdr_phase;
  order_e              order_q;
  logic [2:0]          matched_q;
  logic [HdrLenW-1:0]  hdr_left_q;
  logic [SkipCntW-1:0] skip_q;

  hunt_result_t        expected_q[$];
  bit                  calm = 1'b0;
  int unsigned         n_sent = 0;
  int unsigned         n_checked = 0;
  int unsigned         n_errors = 0;
  int unsigned         kind_seen[4] = '{default: 0};
  int unsigned         stall_cycles = 0;

  sync_tag_hunt_header_capture dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic void restart_hunt();
    hdr_phase  = 1'b0;
    order_q    = OrderNone;
    matched_q  = '0;
    hdr_left_q = '0;
    skip_q     = '0;
  endfunction

  function automatic void add_skipped(input int unsigned n);
    logic [SkipCntW:0] sum;
    sum = {1'b0, skip_q} + n;
    skip_q = sum[SkipCntW] ? '1 : sum[SkipCntW-1:0];
  endfunction

  // Advances the hunt by one request; returns 1 when a result is due.
  function automatic bit predict_hunt(input logic [7:0] b, input logic eos,
                                      output hunt_result_t r);
    logic       rev;
    logic       last;
    logic [1:0] pos;
    logic [7:0] want;
    r = '0;
    rev = (order_q == OrderRev);
    if (eos) begin
      r.kind = hdr_phase ? KindShort : KindEndHunt;
      r.rev  = hdr_phase ? rev : 1'b0;
      restart_hunt();
      return 1'b1;
    end
    if (hdr_phase) begin
      last = (hdr_left_q <= 1);
      r.kind = KindHeader;
      r.hdr  = b;
      r.rev  = rev;
      r.last = last;
      if (last) restart_hunt();
      else hdr_left_q = hdr_left_q - 1'b1;
      return 1'b1;
    end
    if (order_q == OrderNone || matched_q == 0 || matched_q > 3) begin
      if (b == TagBytes[0]) begin
        order_q = OrderFwd;
      end else if (b == TagBytes[3]) begin
        order_q = OrderRev;
      end else begin
        order_q   = OrderNone;
        matched_q = '0;
        add_skipped(1);
        return 1'b0;
      end
      matched_q = 3'd1;
      return 1'b0;
    end
    pos  = matched_q[1:0];
    want = (order_q == OrderFwd) ? TagBytes[pos] : TagBytes[2'd3 - pos];
    // The byte that breaks a partial tag is not tried as a new tag start.
    if (b != want) begin
      add_skipped(matched_q + 1);
      order_q   = OrderNone;
      matched_q = '0;
      return 1'b0;
    end
    matched_q = matched_q + 1'b1;
    if (matched_q == 3'd4) begin
      r.kind     = KindSync;
      r.rev      = rev;
      r.skip     = skip_q;
      hdr_phase  = 1'b1;
      matched_q  = '0;
      hdr_left_q = HdrLenW'(HdrLen);
      skip_q     = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic string show_result(input hunt_result_t r);
    return $sformatf("kind %0d hdr %h rev %0b skip %0d last %0b pad %h",
                     r.kind, r.hdr, r.rev, r.skip, r.last, r.pad);
  endfunction

  task automatic send_req(input logic [7:0] b, input logic eos);
    hunt_result_t r;
    forever begin
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 99) < 33) begin
        s_axis_tvalid = 1'b0;
      end else begin
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = eos ? 8'($urandom_range(0, 255)) : b;
        s_axis_tlast  = eos;
        break;
      end
    end
    do @(posedge clk_i); while (!s_axis_tready);
    n_sent++;
    if (predict_hunt(b, eos, r)) expected_q.push_back(r);
  endtask

  task automatic send_header(input int unsigned n);
    for (int i = 0; i < n; i++) begin
      send_req((i == 0) ? 8'h00 : (i == HdrLen - 1) ? 8'hFF : 8'(i * 8'h15), 1'b0);
    end
  endtask

  task automatic test_forward_tag_with_header();
    send_req(8'h00, 1'b0);
    send_req(8'hFF, 1'b0);
    for (int i = 0; i < 4; i++) send_req(TagBytes[i], 1'b0);
    send_header(HdrLen);
  endtask

  task automatic test_reversed_tag_short_header();
    for (int i = 3; i >= 0; i--) send_req(TagBytes[i], 1'b0);
    send_header(1);
    send_req(8'h00, 1'b1);
  endtask

  // A repeated first byte breaks the tag and is skipped, so the rest of the
  // forward tag does not match; the final 37 starts a reversed hunt instead.
  task automatic test_broken_tag_end_in_hunt();
    send_req(TagBytes[0], 1'b0);
    for (int i = 0; i < 4; i++) send_req(TagBytes[i], 1'b0);
    send_req(8'hFF, 1'b1);
  endtask

  task automatic send_random_frame();
    int unsigned n_skip;
    int unsigned hl;
    int unsigned k;
    int unsigned shape;
    bit          rev;
    n_skip = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 5);
    repeat (n_skip) send_req(8'($urandom_range(0, 255)), 1'b0);
    rev   = 1'($urandom_range(0, 1));
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      send_req(8'($urandom_range(0, 255)), 1'b1);
    end else if (shape == 1) begin
      k = $urandom_range(1, 3);
      for (int i = 0; i < k; i++) send_req(rev ? TagBytes[3 - i] : TagBytes[i], 1'b0);
      send_req(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      for (int i = 0; i < 4; i++) send_req(rev ? TagBytes[3 - i] : TagBytes[i], 1'b0);
      hl = ($urandom_range(0, 4) == 0) ? $urandom_range(0, HdrLen - 1) : HdrLen;
      repeat (hl) send_req(8'($urandom_range(0, 255)), 1'b0);
      if (hl < HdrLen) send_req(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  task automatic test_random_frames(input int unsigned n_items);
    int unsigned stop;
    stop = n_sent + n_items;
    while (n_sent < stop) send_random_frame();
  endtask

  always @(negedge clk_i) begin
    m_axis_tready = calm || ($urandom_range(0, 99) >= 33);
  end

  always @(posedge clk_i) begin : check_results
    hunt_result_t want;
    hunt_result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.pad  = m_axis_tdata[47:41];
      got.kind = kind_e'(m_axis_tuser);
      got.hdr  = m_axis_tdata[7:0];
      got.rev  = m_axis_tdata[8];
      got.skip = m_axis_tdata[40:9];
      got.last = m_axis_tlast;
      if (expected_q.size() == 0) begin
        n_errors++;
        $display("%0t: result with none expected: %s", $time, show_result(got));
      end else begin
        want = expected_q.pop_front();
        n_checked++;
        kind_seen[got.kind]++;
        if (got !== want) begin
          n_errors++;
          $display("%0t: mismatch, expected %s, actual %s", $time,
                   show_result(want), show_result(got));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= StallLimit) begin
      $display("%0t: no request or result moved for %0d cycles", $time, StallLimit);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    restart_hunt();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_forward_tag_with_header();
    test_reversed_tag_short_header();
    test_broken_tag_end_in_hunt();
    test_random_frames(450);
    calm = 1'b1;
    test_random_frames(250);
    calm = 1'b0;
    test_random_frames(400);

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    s_axis_tlast  = 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("tb: %0d stream bytes and ends sent, %0d results checked", n_sent, n_checked);
    $display("tb: sync %0d, header bytes %0d, end in hunt %0d, short header %0d",
             kind_seen[KindSync], kind_seen[KindHeader], kind_seen[KindEndHunt],
             kind_seen[KindShort]);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sync_tag_hunt_header_capture.f
+incdir+src
src/sthhc_pkg.sv
src/sync_tag_hunt_header_capture.sv
bench/tb_sync_tag_hunt_header_capture.sv
